/* design/ms_pkg.sv */
// ----------------------------------------------------------------------------
// Merge sorter package
// Shared word type, cell operation codes and the link between sorting cells.
// ----------------------------------------------------------------------------
package ms_pkg;

    localparam int unsigned WORD_W = 64;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SHIFT
    } t_cell_op;

    // What one cell shows to its neighbors.
    typedef struct packed {
        logic  valid;
        logic  lt;      // broadcast word sorts before this cell's word
        t_word value;
    } t_cell_link;

endpackage

/* design/ms_cell.sv */
// ----------------------------------------------------------------------------
// Sorting cell
// Holds one word of the sorted row, inserts the broadcast word or takes its
// lower neighbor's word while loading, and takes its upper neighbor's word
// while the row drains.
// ----------------------------------------------------------------------------
module ms_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ms_pkg::t_cell_op  i_op,
    input  ms_pkg::t_word     i_x,
    input  ms_pkg::t_cell_link i_prev,
    input  ms_pkg::t_cell_link i_next,
    output ms_pkg::t_cell_link o_link
);
    import ms_pkg::*;

    logic  r_valid;
    t_word r_value;
    logic  w_lt;

    // An empty cell counts as larger than anything. Equal words do not
    // displace, so the earlier word stays in front.
    assign w_lt = !r_valid || (i_x < r_value);

    assign o_link.valid = r_valid;
    assign o_link.lt    = w_lt;
    assign o_link.value = r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            case (i_op)
                CELL_LOAD: begin
                    if (w_lt) begin
                        r_valid <= i_prev.lt ? i_prev.valid : 1'b1;
                    end
                end
                CELL_SHIFT: r_valid <= i_next.valid;
                default:    r_valid <= r_valid;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            CELL_LOAD: begin
                if (w_lt) begin
                    r_value <= i_prev.lt ? i_prev.value : i_x;
                end
            end
            CELL_SHIFT: r_value <= i_next.value;
            default:    r_value <= r_value;
        endcase
    end

endmodule

/* design/merge_sorter_top.sv */
// ----------------------------------------------------------------------------
// Merge sorter top level
// Stable ascending sort of a list of signed 64-bit words on a row of cells.
// ----------------------------------------------------------------------------
// A list is loaded one word per cycle; each word is inserted into a row of
// MAX_ITEMS cells that is kept in ascending order, with equal words staying
// in arrival order. After the word flagged last, the row drains one sorted
// word per cycle from its head while the output side is ready, and no input
// is taken during the drain. Words beyond MAX_ITEMS are dropped and every
// result of that list carries the overflow flag.
module merge_sorter_top #(
    parameter int unsigned MAX_ITEMS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ms_pkg::t_word i_value,
    input  logic          i_is_last,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ms_pkg::t_word o_sorted_value,
    output logic          o_is_final,
    output logic          o_overflowed
);
    import ms_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    localparam t_cell_link EDGE_HEAD = '{valid: 1'b0, lt: 1'b0, value: '0};
    localparam t_cell_link EDGE_TAIL = '{valid: 1'b0, lt: 1'b1, value: '0};

    logic [CNT_W-1:0] r_count;
    logic             r_ovf;
    logic             r_drain;

    logic       w_in_acc;
    logic       w_out_acc;
    logic       w_room;
    t_cell_op   w_op;
    t_cell_link w_link [MAX_ITEMS];

    assign w_room    = (r_count < CNT_MAX);
    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_acc = o_out_valid && i_out_ready;

    assign o_in_ready     = !r_drain;
    assign o_out_valid    = r_drain;
    assign o_sorted_value = w_link[0].value;
    assign o_is_final     = (r_count == CNT_ONE);
    assign o_overflowed   = r_ovf;

    always_comb begin
        if (w_in_acc && w_room) begin
            w_op = CELL_LOAD;
        end else if (w_out_acc) begin
            w_op = CELL_SHIFT;
        end else begin
            w_op = CELL_HOLD;
        end
    end

    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        t_cell_link w_prev;
        t_cell_link w_next;

        if (g == 0) begin : g_head
            assign w_prev = EDGE_HEAD;
        end else begin : g_mid_prev
            assign w_prev = w_link[g-1];
        end

        if (g == MAX_ITEMS - 1) begin : g_tail
            assign w_next = EDGE_TAIL;
        end else begin : g_mid_next
            assign w_next = w_link[g+1];
        end

        ms_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (w_op),
            .i_x     (i_value),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_link  (w_link[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_drain <= 1'b0;
        end else if (w_in_acc) begin
            if (w_room) begin
                r_count <= r_count + CNT_ONE;
            end else begin
                r_ovf <= 1'b1;
            end
            r_drain <= i_is_last;
        end else if (w_out_acc) begin
            r_count <= r_count - CNT_ONE;
            if (o_is_final) begin
                r_drain <= 1'b0;
                r_ovf   <= 1'b0;
            end
        end
    end

    // A drain always starts with at least one stored word.
    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain |-> (r_count != '0))
        else $error("drain with an empty cell row");

    // The head cell holds a word whenever a result is offered.
    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> w_link[0].valid)
        else $error("result offered from an empty head cell");

    // Taking the final word empties the row and reopens the input.
    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_is_final) |=> (r_count == '0 && !r_drain && !r_ovf))
        else $error("list not cleared after its final word");

    // The stored count never exceeds the number of cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("word count beyond capacity");

endmodule
